// File: hw/rtl/potb_pkg.sv
// Shared types and constants for the periodic / one-shot timer bank.
// Holds the command codes, the controller state type and the
// controller <-> datapath command and status structs. No dependencies.
package potb_pkg;

	// Bank geometry; slot 0 is reserved and never allocated
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);

	// Field widths of one input item and one result item
	localparam int CMD_W    = 3;
	localparam int ID_W     = 4;
	localparam int PERIOD_W = 31;
	localparam int S_DATA_W = 40;  // cmd, timer_id, period, one_shot, zero pad
	localparam int M_DATA_W = 8;   // status, result_id, zero pad

	// Command codes; the two codes above CMD_RESET are rejected
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_CREATE = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_START  = 3'd3,
		CMD_STOP   = 3'd4,
		CMD_RESET  = 3'd5
	} cmd_t;

	// Result status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FAIL = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_FLUSH
	} state_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic load;   // capture the input beat, rewind the scan
		logic exec;   // carry out a non-tick command and post its result
		logic scan;   // process the current slot of a tick and advance
		logic flush;  // post the held firing as the final result of a tick
	} dp_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic in_tick;     // input beat on offer is a tick
		logic out_free;    // output register can take a result this cycle
		logic scan_stall;  // current slot fires but the held firing cannot leave
		logic scan_end;    // scan sits on the last slot
		logic pend_valid;  // a firing is held back awaiting its last flag
	} dp_stat_t;

endpackage

// File: hw/rtl/potb_ctrl.sv
// Controller state machine of the timer bank.
// Sequences command execution, the slot scan of a tick and the final flush.
// Depends on potb_pkg.
module potb_ctrl
	import potb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  dp
);

	state_t state_q;
	state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = stat.in_tick ? S_SCAN : S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!stat.scan_stall && stat.scan_end) begin
					state_nxt = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!stat.pend_valid || stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		s_tready = 1'b0;
		dp       = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				dp.load  = s_tvalid;
			end
			S_EXEC: begin
				dp.exec = stat.out_free;
			end
			S_SCAN: begin
				dp.scan = !stat.scan_stall;
			end
			S_FLUSH: begin
				dp.flush = stat.pend_valid && stat.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

// File: hw/rtl/potb_datapath.sv
// Datapath of the timer bank: slot flags and counts, command register,
// scan counter, held firing and the output register.
// Depends on potb_pkg; driven by potb_ctrl.
module potb_datapath
	import potb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [0] status, [4:1] result_id, [7:5] zero
	output logic                m_tuser,   // [0] fired
	output logic                m_tlast,
	input  dp_cmd_t             dp,
	output dp_stat_t            stat
);

	// Slot state
	logic [NUM_SLOTS-1:0] in_use_q;
	logic [NUM_SLOTS-1:0] running_q;
	logic [NUM_SLOTS-1:0] once_q;
	logic [PERIOD_W-1:0]  period_q [NUM_SLOTS];
	logic [PERIOD_W-1:0]  remain_q [NUM_SLOTS];

	// Command register and scan control
	logic [CMD_W-1:0]    cmd_q;
	logic [ID_W-1:0]     id_q;
	logic [PERIOD_W-1:0] per_in_q;
	logic                one_shot_q;
	logic [SLOT_W-1:0]   scan_q;
	logic                pend_valid_q;
	logic [SLOT_W-1:0]   pend_id_q;

	// Output register
	logic              out_valid_q;
	logic              out_status_q;
	logic [ID_W-1:0]   out_id_q;
	logic              out_fired_q;
	logic              out_last_q;

	// Combinational datapath signals
	logic                id_ok;
	logic                id_in_range;
	logic [SLOT_W-1:0]   id_idx;
	logic [SLOT_W-1:0]   rd_idx;
	logic [SLOT_W-1:0]   wr_idx;
	logic [PERIOD_W-1:0] per_rd;
	logic [PERIOD_W-1:0] rem_rd;
	logic [PERIOD_W-1:0] rem_dec;
	logic                hit;
	logic                fire;
	logic                out_free;
	logic [SLOT_W-1:0]   free_idx;
	logic                free_found;
	logic                use_we, use_wd;
	logic                run_we, run_wd;
	logic                once_we, once_wd;
	logic                rem_we;
	logic [PERIOD_W-1:0] rem_wd;
	logic                per_we;
	logic [PERIOD_W-1:0] per_wd;
	logic                push;
	logic                push_status;
	logic [ID_W-1:0]     push_id;
	logic                push_fired;
	logic                push_last;
	logic                pend_set;

	// Id checks; the command id doubles as the read address outside a tick
	assign id_in_range = (int'(id_q) < NUM_SLOTS);
	assign id_ok       = (id_q != '0) && id_in_range;
	assign id_idx      = SLOT_W'(id_q);
	assign rd_idx      = (cmd_q == CMD_TICK) ? scan_q : id_idx;
	assign per_rd      = period_q[rd_idx];
	assign rem_rd      = remain_q[rd_idx];
	assign rem_dec     = rem_rd - PERIOD_W'(1);

	// Current scan slot counts down, and fires on its last count
	assign hit  = in_use_q[rd_idx] && running_q[rd_idx] && (rem_rd != '0);
	assign fire = hit && (rem_dec == '0);

	assign out_free = !out_valid_q || m_tready;

	// Lowest free slot from 1 upward
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
			if (!in_use_q[i]) begin
				free_idx   = SLOT_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// Status to the controller
	always_comb begin
		stat.in_tick    = (s_tdata[CMD_W-1:0] == CMD_TICK);
		stat.out_free   = out_free;
		stat.scan_stall = fire && pend_valid_q && !out_free;
		stat.scan_end   = (scan_q == SLOT_W'(NUM_SLOTS - 1));
		stat.pend_valid = pend_valid_q;
	end

	// Slot updates and result selection
	always_comb begin
		use_we      = 1'b0;
		use_wd      = 1'b0;
		run_we      = 1'b0;
		run_wd      = 1'b0;
		once_we     = 1'b0;
		once_wd     = 1'b0;
		rem_we      = 1'b0;
		rem_wd      = '0;
		per_we      = 1'b0;
		per_wd      = per_in_q;
		wr_idx      = rd_idx;
		push        = 1'b0;
		push_status = ST_OK;
		push_id     = id_q;
		push_fired  = 1'b0;
		push_last   = 1'b1;
		pend_set    = 1'b0;
		if (dp.exec) begin
			push = 1'b1;
			unique case (cmd_q)
				CMD_CREATE: begin
					if ((per_in_q != '0) && free_found) begin
						wr_idx  = free_idx;
						use_we  = 1'b1;
						use_wd  = 1'b1;
						run_we  = 1'b1;
						once_we = 1'b1;
						once_wd = one_shot_q;
						rem_we  = 1'b1;
						rem_wd  = per_in_q;
						per_we  = 1'b1;
						push_id = ID_W'(free_idx);
					end else begin
						push_status = ST_FAIL;
						push_id     = '0;
					end
				end
				CMD_DELETE: begin
					if (id_ok) begin
						use_we  = 1'b1;
						run_we  = 1'b1;
						once_we = 1'b1;
						rem_we  = 1'b1;
					end else begin
						push_status = ST_FAIL;
					end
				end
				CMD_START: begin
					if (id_ok) begin
						run_we = 1'b1;
						run_wd = 1'b1;
						rem_we = 1'b1;
						rem_wd = per_rd;
					end else begin
						push_status = ST_FAIL;
					end
				end
				CMD_STOP: begin
					// slot 0 is accepted here
					if (id_in_range) begin
						run_we = 1'b1;
						rem_we = 1'b1;
					end else begin
						push_status = ST_FAIL;
					end
				end
				CMD_RESET: begin
					if ((per_in_q != '0) && id_ok) begin
						run_we = 1'b1;
						run_wd = 1'b1;
						rem_we = 1'b1;
						rem_wd = per_in_q;
						per_we = 1'b1;
					end else begin
						push_status = ST_FAIL;
					end
				end
				default: begin
					push_status = ST_FAIL;
					push_id     = '0;
				end
			endcase
		end else if (dp.scan) begin
			if (hit) begin
				rem_we = 1'b1;
				rem_wd = rem_dec;
				if (fire) begin
					pend_set = 1'b1;
					// free a one-shot timer, reload a repeating one
					if (once_q[rd_idx]) begin
						use_we  = 1'b1;
						run_we  = 1'b1;
						once_we = 1'b1;
						rem_wd  = '0;
					end else begin
						rem_wd = per_rd;
					end
					// an earlier firing of this tick is now known not to be last
					if (pend_valid_q) begin
						push       = 1'b1;
						push_id    = ID_W'(pend_id_q);
						push_fired = 1'b1;
						push_last  = 1'b0;
					end
				end
			end
		end else if (dp.flush) begin
			push       = 1'b1;
			push_id    = ID_W'(pend_id_q);
			push_fired = 1'b1;
		end
	end

	// Slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= '0;
			running_q <= '0;
			once_q    <= '0;
		end else begin
			if (use_we) begin
				in_use_q[wr_idx] <= use_wd;
			end
			if (run_we) begin
				running_q[wr_idx] <= run_wd;
			end
			if (once_we) begin
				once_q[wr_idx] <= once_wd;
			end
		end
	end

	// Slot counts and periods; not reset, and read by a start even on a free slot
	always_ff @(posedge clk) begin
		if (rem_we) begin
			remain_q[wr_idx] <= rem_wd;
		end
		if (per_we) begin
			period_q[wr_idx] <= per_wd;
		end
	end

	// Command capture
	always_ff @(posedge clk) begin
		if (dp.load) begin
			cmd_q      <= s_tdata[CMD_W-1:0];
			id_q       <= s_tdata[CMD_W +: ID_W];
			per_in_q   <= s_tdata[CMD_W+ID_W +: PERIOD_W];
			one_shot_q <= s_tdata[CMD_W+ID_W+PERIOD_W];
		end
	end

	// Scan counter and held firing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			pend_valid_q <= 1'b0;
			pend_id_q    <= '0;
		end else begin
			if (dp.load) begin
				scan_q       <= '0;
				pend_valid_q <= 1'b0;
			end else if (dp.scan) begin
				scan_q <= scan_q + SLOT_W'(1);
				if (pend_set) begin
					pend_valid_q <= 1'b1;
					pend_id_q    <= rd_idx;
				end
			end else if (dp.flush) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// Output register: load a result, drop it once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_status_q <= push_status;
			out_id_q     <= push_id;
			out_fired_q  <= push_fired;
			out_last_q   <= push_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_id_q, out_status_q});
	assign m_tuser  = out_fired_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTH
	// Reserved slot never becomes allocated
	a_slot0_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_use_q[0])
		else $error("reserved slot 0 marked in use");

	// A running allocated slot always has a count left
	a_run_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_use_q[rd_idx] && running_q[rd_idx]) |-> (rem_rd != '0))
		else $error("running timer with zero count");

	// A result never lands on an untaken beat
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("output beat overwritten");

	// A firing report always carries success
	a_fire_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_fired_q) |-> (out_status_q == ST_OK))
		else $error("firing reported with failure status");
`endif

endmodule

// File: hw/rtl/periodic_oneshot_timer_bank_top.sv
// Bank of periodic / one-shot countdown timers driven by a command stream.
// Channels: slave stream s_* carries one command per beat; master stream m_*
// returns results. Command beats are tick, create, delete, start, stop and
// reset period; every command but tick returns one result with tlast set.
// A tick decrements each running timer once and returns one result per timer
// that expires, in slot order, tlast on the final one; a quiet tick returns
// nothing. tuser flags an expiry report.
// A non-tick command is held in the command register and its result is loaded
// into the output register once that is free; a tick walks the slots one per
// cycle while its scan does not stall, through the single shared slot update path,
// and posts its final expiry from the held firing.
// One command is in work at a time; the next beat is taken once it is done.
// Reset clears all slots to free and stopped and empties the output register.
// A stalled receiver holds the output register; a command waits for it, and a
// tick stalls its scan only when a second expiry is found while the previous
// one is still waiting. Depends on potb_pkg, potb_ctrl and potb_datapath.
module periodic_oneshot_timer_bank_top
	import potb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [2:0] cmd, [6:3] timer_id,
	                                       // [37:7] period, [38] one_shot, [39] zero
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [0] status, [4:1] result_id, [7:5] zero
	output logic                m_tuser,   // [0] fired
	output logic                m_tlast
);

	dp_cmd_t  dp;
	dp_stat_t stat;

	// Sequence the commands
	potb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.dp       (dp)
	);

	// Hold slot state and produce results
	potb_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.dp       (dp),
		.stat     (stat)
	);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_oneshot_timer_bank_top: random and directed command
// beats against an in-bench model of the timer slots. Depends on potb_pkg and the RTL.
module tb_top;
	import potb_pkg::*;

	// Codes above CMD_RESET that the bank must reject
	localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER_BEATS = 60;

	typedef struct packed {
		logic [CMD_W-1:0]    op;
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
		logic                once;
	} cmd_beat_t;

	typedef struct packed {
		logic            status;
		logic [ID_W-1:0] id;
		logic            fired;
		logic            last;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // [2:0] cmd, [6:3] timer_id, [37:7] period,
	                                     // [38] one_shot, [39] zero
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // [0] status, [4:1] result_id, [7:5] zero
	logic                m_tuser;        // [0] fired
	logic                m_tlast;

	periodic_oneshot_timer_bank_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Bench-side copy of the slot state
	logic                slot_busy   [NUM_SLOTS] = '{default: 1'b0};
	logic                slot_run    [NUM_SLOTS] = '{default: 1'b0};
	logic                slot_single [NUM_SLOTS] = '{default: 1'b0};
	logic [PERIOD_W-1:0] slot_reload [NUM_SLOTS] = '{default: '0};
	logic [PERIOD_W-1:0] slot_count  [NUM_SLOTS] = '{default: '0};

	cmd_beat_t pending_cmds[$];
	result_t   owed_results[$];
	int        fault_cnt   = 0;
	int        beats_taken = 0;
	int        src_idle    = 0;
	int        snk_idle    = 0;
	int        hold_left   = 0;
	bit        held_once   = 1'b0;
	bit        in_taken    = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic log_fault(input string msg);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("%t %s", $realtime, msg);
	endtask

	// Work out the results of one accepted command and update the slot copy
	task automatic predict_timer_bank(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
	                                  input logic [PERIOD_W-1:0] per, input logic once);
		result_t r;
		result_t expiries[$];
		bit      id_ok;
		bit      placed;
		r        = '{status: ST_OK, id: id, fired: 1'b0, last: 1'b1};
		id_ok    = (id != 0) && (int'(id) < NUM_SLOTS);
		placed   = 1'b0;
		case (op)
			CMD_TICK: begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (slot_busy[s] && slot_run[s] && slot_count[s] != 0) begin
						slot_count[s] = slot_count[s] - 1'b1;
						if (slot_count[s] == 0) begin
							expiries.push_back('{status: ST_OK, id: ID_W'(s),
							                     fired: 1'b1, last: 1'b0});
							if (slot_single[s]) begin
								slot_busy[s]   = 1'b0;
								slot_run[s]    = 1'b0;
								slot_single[s] = 1'b0;
							end else begin
								slot_count[s] = slot_reload[s];
							end
						end
					end
				end
				// only the final expiry of a tick closes the burst
				if (expiries.size() != 0)
					expiries[expiries.size()-1].last = 1'b1;
				foreach (expiries[k])
					owed_results.push_back(expiries[k]);
			end
			CMD_CREATE: begin
				if (per != 0) begin
					for (int s = 1; s < NUM_SLOTS; s++) begin
						if (!placed && !slot_busy[s]) begin
							slot_busy[s]   = 1'b1;
							slot_run[s]    = 1'b0;
							slot_single[s] = once;
							slot_reload[s] = per;
							slot_count[s]  = per;
							r.id           = ID_W'(s);
							placed         = 1'b1;
						end
					end
				end
				if (!placed) begin
					r.status = ST_FAIL;
					r.id     = '0;
				end
				owed_results.push_back(r);
			end
			CMD_DELETE: begin
				if (!id_ok) begin
					r.status = ST_FAIL;
				end else begin
					slot_busy[id]   = 1'b0;
					slot_run[id]    = 1'b0;
					slot_single[id] = 1'b0;
					slot_count[id]  = '0;
				end
				owed_results.push_back(r);
			end
			CMD_START: begin
				if (!id_ok) begin
					r.status = ST_FAIL;
				end else begin
					slot_run[id]   = 1'b1;
					slot_count[id] = slot_reload[id];
				end
				owed_results.push_back(r);
			end
			CMD_STOP: begin
				if (int'(id) >= NUM_SLOTS) begin
					r.status = ST_FAIL;
				end else begin
					slot_run[id]   = 1'b0;
					slot_count[id] = '0;
				end
				owed_results.push_back(r);
			end
			CMD_RESET: begin
				// a zero period fails ahead of the id test
				if (per == 0 || !id_ok) begin
					r.status = ST_FAIL;
				end else begin
					slot_run[id]    = 1'b1;
					slot_reload[id] = per;
					slot_count[id]  = per;
				end
				owed_results.push_back(r);
			end
			default: begin
				r.status = ST_FAIL;
				r.id     = '0;
				owed_results.push_back(r);
			end
		endcase
	endtask

	task automatic add_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
	                       input logic [PERIOD_W-1:0] per, input logic once);
		pending_cmds.push_back('{op: op, id: id, period: per, once: once});
	endtask

	// Mostly short periods so that timers expire often
	function automatic logic [PERIOD_W-1:0] pick_period();
		int r;
		r = $urandom_range(99);
		if (r < 78)
			return PERIOD_W'($urandom_range(4, 1));
		else if (r < 86)
			return '0;
		else if (r < 95)
			return PERIOD_W'($urandom);
		else
			return PERIOD_MAX;
	endfunction

	task automatic queue_random(input int n);
		int                  pick;
		logic [CMD_W-1:0]    op;
		logic [ID_W-1:0]     id;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			// favour the low slots, where creates land
			id = ($urandom_range(9) < 7) ? ID_W'($urandom_range(8, 1))
			                             : ID_W'($urandom_range(15, 0));
			if (pick < 38)      op = CMD_TICK;
			else if (pick < 55) op = CMD_CREATE;
			else if (pick < 70) op = CMD_START;
			else if (pick < 78) op = CMD_RESET;
			else if (pick < 85) op = CMD_STOP;
			else if (pick < 93) op = CMD_DELETE;
			else if (pick < 96) op = CMD_BAD_LO;
			else                op = CMD_BAD_HI;
			add_cmd(op, id, pick_period(), 1'($urandom_range(1)));
		end
	endtask

	// Fill the bank, overflow it, then arm every slot to expire on one tick
	task automatic queue_fill();
		for (int k = 0; k < NUM_SLOTS; k++)
			add_cmd(CMD_CREATE, ID_W'($urandom_range(15)), PERIOD_W'($urandom_range(3, 1)),
			        1'($urandom_range(1)));
		for (int s = 1; s < NUM_SLOTS; s++)
			add_cmd(CMD_RESET, ID_W'(s), PERIOD_W'(1), 1'($urandom_range(1)));
		add_cmd(CMD_TICK, '0, '0, 1'b0);
		add_cmd(CMD_TICK, '1, PERIOD_MAX, 1'b1);
	endtask

	task automatic queue_directed();
		add_cmd(CMD_TICK,   4'd0,  '0,           1'b0); // quiet tick on an empty bank
		add_cmd(CMD_CREATE, 4'd0,  '0,           1'b0); // zero period rejected
		add_cmd(CMD_CREATE, 4'd0,  PERIOD_W'(1), 1'b0); // slot 1, repeating
		add_cmd(CMD_CREATE, 4'd0,  PERIOD_MAX,   1'b1); // slot 2, never expires here
		add_cmd(CMD_CREATE, 4'd0,  PERIOD_W'(2), 1'b1); // slot 3, one-shot
		add_cmd(CMD_START,  4'd1,  '0,           1'b0);
		add_cmd(CMD_START,  4'd2,  '0,           1'b0);
		add_cmd(CMD_START,  4'd3,  '0,           1'b0);
		add_cmd(CMD_TICK,   4'd0,  '0,           1'b0);
		add_cmd(CMD_TICK,   4'd0,  '0,           1'b0); // two expiries, one-shot frees
		add_cmd(CMD_START,  4'd0,  '0,           1'b0); // reserved slot
		add_cmd(CMD_DELETE, 4'd0,  '0,           1'b0);
		add_cmd(CMD_RESET,  4'd0,  PERIOD_W'(5), 1'b0);
		add_cmd(CMD_RESET,  4'd1,  '0,           1'b0); // zero period fails first
		add_cmd(CMD_STOP,   4'd0,  '0,           1'b0); // stop on slot 0 succeeds
		add_cmd(CMD_STOP,   4'd15, '0,           1'b0); // free slot
		add_cmd(CMD_START,  4'd15, '0,           1'b0); // free slot, must stay silent
		add_cmd(CMD_TICK,   4'd0,  '0,           1'b0);
		add_cmd(CMD_BAD_LO, 4'd9,  PERIOD_MAX,   1'b1);
		add_cmd(CMD_BAD_HI, 4'd15, PERIOD_W'(3), 1'b0);
		add_cmd(CMD_RESET,  4'd1,  PERIOD_W'(3), 1'b0);
		add_cmd(CMD_DELETE, 4'd2,  '0,           1'b0);
		add_cmd(CMD_DELETE, 4'd2,  '0,           1'b0); // delete twice
		add_cmd(CMD_CREATE, 4'd0,  PERIOD_W'(1), 1'b1); // reuses slot 2
		add_cmd(CMD_TICK,   4'd0,  '0,           1'b0);
	endtask

	// Hold the sender until every beat is out and every result is back
	task automatic wait_drained();
		int guard;
		guard = 0;
		do begin
			@(negedge clk);
			guard++;
		end while (!(pending_cmds.size() == 0 && !s_tvalid && owed_results.size() == 0)
		           && guard < 50_000);
		@(posedge clk);
	endtask

	// Stimulus sequence and verdict
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);
		src_idle = 23;
		snk_idle = 83;
		queue_directed();
		queue_random(60);
		wait_drained();
		src_idle = 83;
		snk_idle = 23;
		queue_fill();
		queue_random(45);
		wait_drained();
		src_idle = 0;
		snk_idle = 0;
		queue_random(60);
		wait_drained();
		repeat (2 * NUM_SLOTS + 8) @(posedge clk);
		@(negedge clk);
		if (owed_results.size() != 0)
			log_fault($sformatf("%0d results never arrived", owed_results.size()));
		if (fault_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Command driver: advance on acceptance, idle at random
	always @(negedge clk) begin : cmd_driver
		cmd_beat_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_taken) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle) begin
				nxt = pending_cmds.pop_front();
				s_tdata  <= {1'b0, nxt.once, nxt.period, nxt.id, nxt.op};
				s_tvalid <= 1'b1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, once, to back the bank up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!held_once && beats_taken >= HOLD_AFTER_BEATS) begin
				hold_left <= HOLD_CYCLES;
				held_once <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// Result receiver: stall at random or during the hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_left != 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Monitor: check result beats, predict from command beats
	always @(posedge clk) begin : beat_monitor
		result_t seen;
		result_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				seen = '{status: m_tdata[0], id: m_tdata[4:1], fired: m_tuser, last: m_tlast};
				if (owed_results.size() == 0) begin
					log_fault($sformatf("unexpected result: status %0d id %0d fired %0d last %0d",
					                    seen.status, seen.id, seen.fired, seen.last));
				end else begin
					want = owed_results.pop_front();
					if (seen !== want)
						log_fault($sformatf({"result mismatch: want status %0d id %0d fired %0d",
						                     " last %0d, got status %0d id %0d fired %0d last %0d"},
						                    want.status, want.id, want.fired, want.last,
						                    seen.status, seen.id, seen.fired, seen.last));
				end
			end
			if (s_tvalid && s_tready) begin
				predict_timer_bank(s_tdata[2:0], s_tdata[6:3], s_tdata[37:7], s_tdata[38]);
				beats_taken <= beats_taken + 1;
			end
		end
	end

endmodule

// File: sim.f
hw/rtl/potb_pkg.sv
hw/rtl/potb_ctrl.sv
hw/rtl/potb_datapath.sv
hw/rtl/periodic_oneshot_timer_bank_top.sv
bench/tb_top.sv
